[src/ase_pkg.sv]
// ----------------------------------------------------------------------------
// ase_pkg
// Shared types and constants of the streaming ANS encoder.
// ----------------------------------------------------------------------------
package ase_pkg;

  // Parameter defaults
  localparam int unsigned MAX_SYMBOLS_DEF    = 16;
  localparam int unsigned MAX_LOG2_TOTAL_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BITCNT_W   = 5;
  localparam int unsigned BITS_W     = 17;
  localparam int unsigned FSTATE_W   = 17;
  localparam int unsigned TOTBITS_W  = 32;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_ZERO    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Control part of a classified request, front to back
  typedef struct packed {
    op_e     kind;
    status_e status;
  } cmd_ctl_t;

endpackage

[src/ase_front.sv]
// ----------------------------------------------------------------------------
// ase_front
// Accepts requests, owns the symbol table, matches symbol values and
// classifies each request into a command for the coder back end.
// ----------------------------------------------------------------------------
module ase_front #(
  parameter int unsigned MAX_SYMBOLS    = ase_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned MAX_LOG2_TOTAL = ase_pkg::MAX_LOG2_TOTAL_DEF,
  localparam int unsigned TW            = MAX_LOG2_TOTAL + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ase_pkg::op_e                      op_i,
  input  logic [ase_pkg::INDEX_W-1:0]       index_i,
  input  logic [ase_pkg::VALUE_W-1:0]       value_i,
  input  logic [ase_pkg::COUNT_W-1:0]       count_i,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i,
  output ase_pkg::cmd_ctl_t                 cmd_ctl_o,
  output logic [ase_pkg::COUNT_W-1:0]       cmd_count_o,
  output logic [TW-1:0]                     cmd_base_o,
  output logic [TW-1:0]                     cmd_total_o
);

  localparam int unsigned IW = $clog2(MAX_SYMBOLS);
  localparam int unsigned NW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned CW = ase_pkg::COUNT_W;
  localparam int unsigned EW = ((TW > CW) ? TW : CW) + 1;
  localparam int unsigned MW = CW + TW;
  localparam logic [TW-1:0] LIMIT = {1'b1, {MAX_LOG2_TOTAL{1'b0}}};

  // Table state
  logic [ase_pkg::VALUE_W-1:0] value_q [MAX_SYMBOLS];
  logic [MW-1:0]               entry_mem [MAX_SYMBOLS];
  logic [NW-1:0]               entries_q, entries_d;
  logic [TW-1:0]               total_q, total_d;
  logic                        bad_q, bad_d;

  logic                        accept;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [NW-1:0]               n_base;
  logic [TW-1:0]               tot_base;
  logic                        bad_base;
  logic                        ovf;
  ase_pkg::status_e            load_status;
  logic                        table_ok;
  logic [MAX_SYMBOLS-1:0]      match;

  // Stage 1: match vector
  logic                        s1_v_q;
  ase_pkg::op_e                s1_kind_q;
  ase_pkg::status_e            s1_status_q, s1_status_d;
  logic                        s1_ok_q;
  logic [MAX_SYMBOLS-1:0]      s1_match_q;
  logic [TW-1:0]               s1_total_q;

  // Stage 2: hit entry read out
  logic                        s2_v_q;
  ase_pkg::op_e                s2_kind_q;
  ase_pkg::status_e            s2_status_q;
  logic                        s2_ok_q;
  logic                        s2_found_q;
  logic [TW-1:0]               s2_total_q;
  logic [MW-1:0]               rd_q;

  logic                        s1_adv;
  logic                        s2_en;
  logic [IW-1:0]               hit;
  logic                        found;
  logic [CW-1:0]               hit_count;
  logic [TW-1:0]               hit_start;
  logic [EW-1:0]               base_wide;
  ase_pkg::status_e            out_status;

  assign s2_en      = !s2_v_q || cmd_ready_i;
  assign s1_adv     = s1_v_q && s2_en;
  assign in_ready_o = !s1_v_q || s2_en;
  assign accept     = in_valid_i && in_ready_o;

  // Load handling; index 0 restarts the table
  always_comb begin
    n_base      = (index_i == '0) ? '0 : entries_q;
    tot_base    = (index_i == '0) ? '0 : total_q;
    bad_base    = (index_i == '0) ? 1'b0 : bad_q;
    ovf         = EW'(count_i) > EW'(LIMIT - tot_base);
    entries_d   = entries_q;
    total_d     = total_q;
    bad_d       = bad_q;
    wr_en       = 1'b0;
    wr_addr     = n_base[IW-1:0];
    load_status = ase_pkg::ST_OK;
    if (accept && op_i == ase_pkg::OP_LOAD) begin
      entries_d = n_base;
      total_d   = tot_base;
      bad_d     = bad_base;
      if (n_base == NW'(MAX_SYMBOLS)) begin
        bad_d       = 1'b1;
        load_status = ase_pkg::ST_INVALID;
      end else begin
        wr_en     = 1'b1;
        entries_d = n_base + 1'b1;
        if (ovf) begin
          bad_d       = 1'b1;
          load_status = ase_pkg::ST_INVALID;
        end else begin
          total_d = TW'(EW'(tot_base) + EW'(count_i));
          if (count_i == '0) begin
            load_status = ase_pkg::ST_ZERO;
          end
        end
      end
    end
  end

  assign table_ok = (entries_q != '0) && !bad_q && (total_q != '0) &&
                    ((total_q & (total_q - 1'b1)) == '0);

  always_comb begin
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      match[i] = (NW'(i) < entries_q) && (value_q[i] == value_i);
    end
  end

  always_comb begin
    case (op_i)
      ase_pkg::OP_LOAD:   s1_status_d = load_status;
      ase_pkg::OP_ENCODE,
      ase_pkg::OP_FINISH: s1_status_d = table_ok ? ase_pkg::ST_OK : ase_pkg::ST_INVALID;
      default:            s1_status_d = ase_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
      total_q   <= '0;
      bad_q     <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
    end else begin
      entries_q <= entries_d;
      total_q   <= total_d;
      bad_q     <= bad_d;
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q   <= op_i;
      s1_status_q <= s1_status_d;
      s1_ok_q     <= table_ok;
      s1_match_q  <= match;
      s1_total_q  <= total_d;
    end
    if (s1_adv) begin
      s2_kind_q   <= s1_kind_q;
      s2_status_q <= s1_status_q;
      s2_ok_q     <= s1_ok_q;
      s2_found_q  <= found;
      s2_total_q  <= s1_total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      value_q[wr_addr] <= value_i;
    end
  end

  // Last matching entry wins
  always_comb begin
    hit   = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (s1_match_q[i]) begin
        hit   = IW'(i);
        found = 1'b1;
      end
    end
  end

  // Count and start memory; read sees the table as of the request's match
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= {count_i, tot_base};
    end
    if (s1_adv) begin
      rd_q <= entry_mem[hit];
    end
  end

  assign hit_count = rd_q[MW-1:TW];
  assign hit_start = rd_q[TW-1:0];
  assign base_wide = EW'(s2_total_q) + EW'(hit_start) - EW'(hit_count);

  always_comb begin
    out_status = s2_status_q;
    if (s2_kind_q == ase_pkg::OP_ENCODE) begin
      if (!s2_ok_q) begin
        out_status = ase_pkg::ST_INVALID;
      end else if (!s2_found_q) begin
        out_status = ase_pkg::ST_UNKNOWN;
      end else if (hit_count == '0) begin
        out_status = ase_pkg::ST_ZERO;
      end else begin
        out_status = ase_pkg::ST_OK;
      end
    end
  end

  assign cmd_valid_o      = s2_v_q;
  assign cmd_ctl_o.kind   = s2_kind_q;
  assign cmd_ctl_o.status = out_status;
  assign cmd_count_o      = hit_count;
  assign cmd_base_o       = base_wide[TW-1:0];
  assign cmd_total_o      = s2_total_q;

endmodule

[src/ase_queue.sv]
// ----------------------------------------------------------------------------
// ase_queue
// Short command queue between the front end and the coder back end.
// ----------------------------------------------------------------------------
module ase_queue #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = ase_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[src/ase_back.sv]
// ----------------------------------------------------------------------------
// ase_back
// Coder back end: keeps the coder state and bit total, renormalizes and
// encodes one command per cycle into a registered result unless stalled.
// ----------------------------------------------------------------------------
module ase_back #(
  parameter int unsigned MAX_LOG2_TOTAL = ase_pkg::MAX_LOG2_TOTAL_DEF,
  localparam int unsigned TW            = MAX_LOG2_TOTAL + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  ase_pkg::cmd_ctl_t                 cmd_ctl_i,
  input  logic [ase_pkg::COUNT_W-1:0]       cmd_count_i,
  input  logic [TW-1:0]                     cmd_base_i,
  input  logic [TW-1:0]                     cmd_total_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ase_pkg::status_e                  out_status_o,
  output logic [ase_pkg::BITCNT_W-1:0]      out_bit_count_o,
  output logic [ase_pkg::BITS_W-1:0]        out_bits_o,
  output logic [ase_pkg::FSTATE_W-1:0]      out_final_state_o,
  output logic [ase_pkg::TOTBITS_W-1:0]     out_total_bits_o
);

  localparam int unsigned KW   = $clog2(TW + 1);
  localparam int unsigned CMPW = (TW > ase_pkg::COUNT_W + 1) ? TW : ase_pkg::COUNT_W + 1;

  logic [TW-1:0]                 state_q, state_d;
  logic [ase_pkg::TOTBITS_W-1:0] bitcnt_q, bitcnt_d;
  logic                          out_valid_q;
  ase_pkg::status_e              status_q;
  logic [ase_pkg::BITCNT_W-1:0]  bit_count_q, bit_count_d;
  logic [ase_pkg::BITS_W-1:0]    bits_q, bits_d;
  logic [ase_pkg::FSTATE_W-1:0]  fstate_q, fstate_d;
  logic [ase_pkg::TOTBITS_W-1:0] totbits_q, totbits_d;

  logic                          fire;
  logic [CMPW-1:0]               twice_count;
  logic [TW-1:0]                 ge;
  logic [KW-1:0]                 k;
  logic [TW-1:0]                 shifted;
  logic [TW+ase_pkg::BITS_W-1:0] bits_ext;
  logic [TW+ase_pkg::FSTATE_W-1:0] state_ext;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  // Parallel compares; ge is a thermometer code, its ones are the shifted bits
  assign twice_count = CMPW'({cmd_count_i, 1'b0});
  always_comb begin
    k = '0;
    for (int j = 0; j < TW; j++) begin
      ge[j] = CMPW'(state_q >> j) >= twice_count;
      if (ge[j]) begin
        k = KW'(j + 1);
      end
    end
  end

  assign shifted   = state_q >> k;
  assign bits_ext  = {{ase_pkg::BITS_W{1'b0}}, state_q & ge};
  assign state_ext = {{ase_pkg::FSTATE_W{1'b0}}, state_q};

  always_comb begin
    state_d     = state_q;
    bitcnt_d    = bitcnt_q;
    bit_count_d = '0;
    bits_d      = '0;
    fstate_d    = '0;
    totbits_d   = '0;
    case (cmd_ctl_i.kind)
      ase_pkg::OP_LOAD: begin
        state_d  = cmd_total_i;
        bitcnt_d = '0;
      end
      ase_pkg::OP_ENCODE: begin
        if (cmd_ctl_i.status == ase_pkg::ST_OK) begin
          state_d     = cmd_base_i + shifted;
          bitcnt_d    = bitcnt_q + ase_pkg::TOTBITS_W'(k);
          bit_count_d = ase_pkg::BITCNT_W'(k);
          bits_d      = bits_ext[ase_pkg::BITS_W-1:0];
        end
      end
      ase_pkg::OP_FINISH: begin
        fstate_d  = state_ext[ase_pkg::FSTATE_W-1:0];
        totbits_d = bitcnt_q;
        state_d   = cmd_total_i;
        bitcnt_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      bitcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q  <= state_d;
        bitcnt_q <= bitcnt_d;
      end
      if (cmd_ready_o) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q    <= cmd_ctl_i.status;
      bit_count_q <= bit_count_d;
      bits_q      <= bits_d;
      fstate_q    <= fstate_d;
      totbits_q   <= totbits_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = status_q;
  assign out_bit_count_o   = bit_count_q;
  assign out_bits_o        = bits_q;
  assign out_final_state_o = fstate_q;
  assign out_total_bits_o  = totbits_q;

endmodule

[src/ans_stream_encoder.sv]
// ----------------------------------------------------------------------------
// ans_stream_encoder
// Streaming table ANS encoder with bitwise renormalization.
// ----------------------------------------------------------------------------
// Requests come in on the s_axis channel, one result per request leaves on
// the m_axis channel in request order. tuser carries the operation (load
// table entry, encode symbol, finish, no-op); the result's tuser is status.
// Table entries are loaded in index order, index 0 restarting the table.
//
// A request passes through two front stages for the value match and entry
// read, the command queue, then the output register. Throughput: one
// request per cycle while m_axis_tready_i keeps up; the coder state
// recurrence is closed combinationally around the back end's state register
// (parallel shift-count compares, shift and add).
//
// Reset empties the pipeline and queue, clears the loaded-entry count,
// running total, coder state and bit total; table contents are not cleared
// and no clearing pass runs. When the receiver stalls, the output register,
// a two-entry command queue and the front stages fill before s_axis_tready_o
// drops; nothing is lost or reordered.
// ----------------------------------------------------------------------------
module ans_stream_encoder #(
  parameter int unsigned MAX_SYMBOLS    = ase_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned MAX_LOG2_TOTAL = ase_pkg::MAX_LOG2_TOTAL_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // entry_index, symbol_value, symbol_count, zero pad
  input  logic [ase_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // operation
  input  logic [ase_pkg::OP_W-1:0]          s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // bit_count, bits, final_state, total_bits, zero pad
  output logic [ase_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // status
  output logic [ase_pkg::STATUS_W-1:0]      m_axis_tuser_o
);

  localparam int unsigned TW = MAX_LOG2_TOTAL + 1;
  localparam int unsigned IX_LO = 0;
  localparam int unsigned VA_LO = IX_LO + ase_pkg::INDEX_W;
  localparam int unsigned CN_LO = VA_LO + ase_pkg::VALUE_W;
  localparam int unsigned BC_LO = 0;
  localparam int unsigned BI_LO = BC_LO + ase_pkg::BITCNT_W;
  localparam int unsigned FS_LO = BI_LO + ase_pkg::BITS_W;
  localparam int unsigned TB_LO = FS_LO + ase_pkg::FSTATE_W;
  localparam int unsigned PAD_W = ase_pkg::OUT_DATA_W - TB_LO - ase_pkg::TOTBITS_W;
  localparam int unsigned CTL_W = $bits(ase_pkg::cmd_ctl_t);
  localparam int unsigned QW    = CTL_W + ase_pkg::COUNT_W + 2 * TW;

  logic                          f_valid, f_ready;
  ase_pkg::cmd_ctl_t             f_ctl, b_ctl;
  logic [ase_pkg::COUNT_W-1:0]   f_count, b_count;
  logic [TW-1:0]                 f_base, b_base, f_total, b_total;
  logic [QW-1:0]                 q_in, q_out;
  logic                          b_valid, b_ready;
  ase_pkg::status_e              o_status;
  logic [ase_pkg::BITCNT_W-1:0]  o_bit_count;
  logic [ase_pkg::BITS_W-1:0]    o_bits;
  logic [ase_pkg::FSTATE_W-1:0]  o_fstate;
  logic [ase_pkg::TOTBITS_W-1:0] o_totbits;

  ase_front #(
    .MAX_SYMBOLS   (MAX_SYMBOLS),
    .MAX_LOG2_TOTAL(MAX_LOG2_TOTAL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (ase_pkg::op_e'(s_axis_tuser_i)),
    .index_i    (s_axis_tdata_i[VA_LO-1:IX_LO]),
    .value_i    (s_axis_tdata_i[CN_LO-1:VA_LO]),
    .count_i    (s_axis_tdata_i[CN_LO+ase_pkg::COUNT_W-1:CN_LO]),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_ctl_o  (f_ctl),
    .cmd_count_o(f_count),
    .cmd_base_o (f_base),
    .cmd_total_o(f_total)
  );

  assign q_in = {f_ctl, f_count, f_base, f_total};

  ase_queue #(
    .DW   (QW),
    .DEPTH(ase_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i (q_in),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_data_o  (q_out)
  );

  assign {b_ctl, b_count, b_base, b_total} = q_out;

  ase_back #(
    .MAX_LOG2_TOTAL(MAX_LOG2_TOTAL)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (b_valid),
    .cmd_ready_o      (b_ready),
    .cmd_ctl_i        (b_ctl),
    .cmd_count_i      (b_count),
    .cmd_base_i       (b_base),
    .cmd_total_i      (b_total),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_status_o     (o_status),
    .out_bit_count_o  (o_bit_count),
    .out_bits_o       (o_bits),
    .out_final_state_o(o_fstate),
    .out_total_bits_o (o_totbits)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, o_totbits, o_fstate, o_bits, o_bit_count};
  assign m_axis_tuser_o = o_status;

endmodule

[src/ase_checker.sv]
// ----------------------------------------------------------------------------
// ase_checker
// Port-level checks of the ANS encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ase_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_i,
  input logic                           m_axis_tvalid_i,
  input logic                           m_axis_tready_i,
  input logic [ase_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  input logic [ase_pkg::STATUS_W-1:0]   m_axis_tuser_i
);

  localparam int unsigned BI_LO = ase_pkg::BITCNT_W;
  localparam int unsigned FS_LO = BI_LO + ase_pkg::BITS_W;
  localparam int unsigned TB_LO = FS_LO + ase_pkg::FSTATE_W;

  logic [3:0]                    pend_q;
  logic                          in_acc, out_acc;
  logic [ase_pkg::BITCNT_W-1:0]  bit_count;
  logic [ase_pkg::BITS_W-1:0]    bits;
  logic [ase_pkg::FSTATE_W-1:0]  fstate;
  logic [ase_pkg::TOTBITS_W-1:0] totbits;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_i;
  assign out_acc   = m_axis_tvalid_i && m_axis_tready_i;
  assign bit_count = m_axis_tdata_i[BI_LO-1:0];
  assign bits      = m_axis_tdata_i[FS_LO-1:BI_LO];
  assign fstate    = m_axis_tdata_i[TB_LO-1:FS_LO];
  assign totbits   = m_axis_tdata_i[TB_LO+ase_pkg::TOTBITS_W-1:TB_LO];

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {3'b0, in_acc} - {3'b0, out_acc};
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> pend_q != '0)
    else $error("result without a pending request");

  a_bits_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (bits >> bit_count) == '0)
    else $error("emitted bits exceed bit count");

  a_encode_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (bit_count != '0 || bits != '0) |->
      m_axis_tuser_i == ase_pkg::ST_OK && fstate == '0 && totbits == '0)
    else $error("encode bits on a non-encode result");

endmodule

bind ans_stream_encoder ase_checker u_ase_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_i(s_axis_tready_o),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o),
  .m_axis_tuser_i (m_axis_tuser_o)
);
